>>> hw/rtl/asc_pkg.sv
// shared types and constants of the accelerometer step counter
// no dependencies; used by asc_isqrt and accel_step_counter_core
package asc_pkg;

	localparam int DEF_SAMPLE_BITS = 10;
	localparam int DEF_FRAC_BITS   = 4;
	localparam int DEF_COUNT_BITS  = 16;

	// resting levels and step level in whole adc units
	localparam int X_REST_LEVEL = 345;
	localparam int Y_REST_LEVEL = 346;
	localparam int Z_REST_LEVEL = 416;
	localparam int STEP_LEVEL   = 6;

	localparam int REG_IDX_BITS = 2;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_X_BASE,
		REG_Y_BASE,
		REG_Z_BASE,
		REG_THRESH
	} asc_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQR,
		ST_ROOT,
		ST_HOLD
	} asc_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} asc_sqrt_stat_t;

endpackage

>>> hw/rtl/accel_step_counter_core.sv
// top level of the accelerometer step counter
// depends on asc_pkg and asc_isqrt
//
// usage:
// one input beat carries an x, y and z adc sample; one output beat per input
// beat carries the averaged deviation magnitude, a step pulse and the total.
// in_stall is high while an item is in work: the three squares go through one
// shared multiplier, then the bit-serial root takes one root bit per cycle,
// and no new item is taken until the result of the last is loaded into the
// output register.
// the result sits in an output register, so the next item is taken while a
// result waits; if the receiver still stalls when the next root is done,
// the block holds that root and stays stalled until the output register frees.
// reset loads the default baselines and threshold, clears the previous
// magnitude, arms the detector and zeroes the step total. configuration
// writes act at once; the user must make them only while idle, unchecked.
module accel_step_counter_core #(
	parameter int SAMPLE_BITS = asc_pkg::DEF_SAMPLE_BITS,
	parameter int FRAC_BITS   = asc_pkg::DEF_FRAC_BITS,
	parameter int COUNT_BITS  = asc_pkg::DEF_COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [asc_pkg::REG_IDX_BITS-1:0]  cfg_index,
	input  logic [SAMPLE_BITS+FRAC_BITS:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [SAMPLE_BITS-1:0]            x_sample,
	input  logic [SAMPLE_BITS-1:0]            y_sample,
	input  logic [SAMPLE_BITS-1:0]            z_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [SAMPLE_BITS+FRAC_BITS:0]    avg_magnitude,
	output logic                              step_pulse,
	output logic [COUNT_BITS-1:0]             step_total
);
	import asc_pkg::*;

	localparam int BASE_BITS = SAMPLE_BITS + FRAC_BITS;
	localparam int MAG_BITS  = BASE_BITS + 1;
	localparam int SUM_BITS  = 2 * MAG_BITS;
	localparam int PROD_BITS = 2 * BASE_BITS;

	localparam logic [BASE_BITS-1:0] X_BASE_RST = BASE_BITS'(X_REST_LEVEL << FRAC_BITS);
	localparam logic [BASE_BITS-1:0] Y_BASE_RST = BASE_BITS'(Y_REST_LEVEL << FRAC_BITS);
	localparam logic [BASE_BITS-1:0] Z_BASE_RST = BASE_BITS'(Z_REST_LEVEL << FRAC_BITS);
	localparam logic [MAG_BITS-1:0]  THRESH_RST = MAG_BITS'(STEP_LEVEL << FRAC_BITS);

	asc_state_t state_q, state_d;

	logic [BASE_BITS-1:0]   x_base_q, y_base_q, z_base_q;
	logic [MAG_BITS-1:0]    thresh_q;

	logic [SAMPLE_BITS-1:0] x_q, y_q, z_q;
	logic [1:0]             sq_cnt_q;
	logic [PROD_BITS-1:0]   sq_q;
	logic [SUM_BITS-1:0]    acc_q;

	logic [MAG_BITS-1:0]    prev_mag_q;
	logic                   above_q;
	logic [COUNT_BITS-1:0]  step_cnt_q;
	logic                   out_valid_q;
	logic [MAG_BITS-1:0]    avg_q;
	logic                   pulse_q;

	logic                   in_take;
	logic                   out_free;
	logic                   load_out;
	logic                   sqrt_start;
	logic [SUM_BITS-1:0]    acc_sum;
	logic [SAMPLE_BITS-1:0] sel_sample;
	logic [BASE_BITS-1:0]   sel_base;
	logic [BASE_BITS-1:0]   scaled;
	logic [BASE_BITS-1:0]   dev;
	logic [MAG_BITS-1:0]    root;
	asc_sqrt_stat_t         sqrt_st;
	logic [MAG_BITS:0]      pair_sum;
	logic [MAG_BITS-1:0]    avg_new;
	logic                   hit;

	asc_isqrt #(
		.MAG_BITS(MAG_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc_sum),
		.root     (root),
		.status   (sqrt_st)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_base_q <= X_BASE_RST;
			y_base_q <= Y_BASE_RST;
			z_base_q <= Z_BASE_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_wr_en) begin
			case (asc_reg_t'(cfg_index))
				REG_X_BASE: x_base_q <= cfg_data[BASE_BITS-1:0];
				REG_Y_BASE: y_base_q <= cfg_data[BASE_BITS-1:0];
				REG_Z_BASE: z_base_q <= cfg_data[BASE_BITS-1:0];
				REG_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		sqrt_start = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SQR;
				end
			end
			ST_SQR: begin
				if (sq_cnt_q == 2'd3) begin
					sqrt_start = 1'b1;
					state_d    = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (sqrt_st.done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// shared squarer: one axis per cycle, product registered before the add
	always_comb begin
		case (sq_cnt_q)
			2'd0: begin
				sel_sample = x_q;
				sel_base   = x_base_q;
			end
			2'd1: begin
				sel_sample = y_q;
				sel_base   = y_base_q;
			end
			2'd2: begin
				sel_sample = z_q;
				sel_base   = z_base_q;
			end
			default: begin
				sel_sample = '0;
				sel_base   = '0;
			end
		endcase
		scaled  = BASE_BITS'({sel_sample, {FRAC_BITS{1'b0}}});
		dev     = (scaled >= sel_base) ? (scaled - sel_base) : (sel_base - scaled);
		acc_sum = acc_q + SUM_BITS'(sq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (in_take) begin
			sq_cnt_q <= '0;
		end else if (state_q == ST_SQR) begin
			sq_cnt_q <= sq_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= x_sample;
			y_q <= y_sample;
			z_q <= z_sample;
		end
		if (state_q == ST_SQR) begin
			sq_q  <= (sel_sample == '0 && sel_base == '0 && sq_cnt_q == 2'd3) ? '0 :
			         PROD_BITS'(dev * dev);
			acc_q <= (sq_cnt_q == 2'd0) ? '0 : acc_sum;
		end
	end

	// average, step detector and output register
	always_comb begin
		pair_sum = {1'b0, root} + {1'b0, prev_mag_q};
		avg_new  = pair_sum[MAG_BITS:1];
		hit      = (avg_new > thresh_q) && !above_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mag_q  <= '0;
			above_q     <= 1'b0;
			step_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				prev_mag_q  <= root;
				if (hit) begin
					above_q <= 1'b1;
					if (step_cnt_q != '1) begin
						step_cnt_q <= step_cnt_q + 1'b1;
					end
				end else if (avg_new < thresh_q) begin
					above_q <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_q   <= avg_new;
			pulse_q <= hit;
		end
	end

	assign out_valid     = out_valid_q;
	assign avg_magnitude = avg_q;
	assign step_pulse    = pulse_q;
	assign step_total    = step_cnt_q;

	// checks
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input taken while an item was still in work");

	a_root_only_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_st.done |-> (state_q == ST_ROOT))
		else $error("root finished outside the root phase");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_st.busy |-> in_stall)
		else $error("input open while the root unit runs");

	a_pulse_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pulse_q) |-> above_q)
		else $error("step pulse shown while detector is armed");

endmodule

>>> hw/rtl/asc_isqrt.sv
// bit-serial floor square root, one root bit per cycle
// depends on asc_pkg for the status struct
module asc_isqrt #(
	parameter int MAG_BITS = asc_pkg::DEF_SAMPLE_BITS + asc_pkg::DEF_FRAC_BITS + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [2*MAG_BITS-1:0]      radicand,
	output logic [MAG_BITS-1:0]        root,
	output asc_pkg::asc_sqrt_stat_t    status
);
	import asc_pkg::*;

	localparam int SUM_BITS  = 2 * MAG_BITS;
	localparam int ITER_BITS = $clog2(MAG_BITS);

	logic [SUM_BITS-1:0]  rad_q;
	logic [MAG_BITS+1:0]  rem_q;
	logic [MAG_BITS-1:0]  root_q;
	logic [ITER_BITS-1:0] iter_q;
	logic                 busy_q;
	logic                 done_q;

	logic [MAG_BITS+1:0]  rem_shift;
	logic [MAG_BITS+1:0]  trial;
	logic                 fits;

	always_comb begin
		rem_shift = {rem_q[MAG_BITS-1:0], rad_q[SUM_BITS-1 -: 2]};
		trial     = {root_q, 2'b01};
		fits      = (rem_shift >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_BITS'(MAG_BITS - 1);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_BITS-3:0], 2'b00};
			rem_q  <= fits ? (rem_shift - trial) : rem_shift;
			root_q <= {root_q[MAG_BITS-2:0], fits};
		end
	end

	assign root        = root_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
